// ===== rtl/stepper_link_response_tracker_defines.svh =====
// Assertion macros for the stepper link response tracker.
// Used by modules that declare clk_i and rst_ni; depends on nothing else.
`ifndef STEPPER_LINK_RESPONSE_TRACKER_DEFINES_SVH
`define STEPPER_LINK_RESPONSE_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slrt_pkg.sv =====
// Shared types, codes and constants for the stepper link response tracker.
// Has no dependencies; the top level refers to it by scoped names.
package slrt_pkg;

  // Frame storage.
  localparam int DataBytes = 8;
  localparam int DataIdxW  = $clog2(DataBytes);
  localparam int CountW    = $clog2(DataBytes + 1);

  // Fixed bytes of the protocol.
  localparam logic [7:0] TailByte = 8'h6B;
  localparam logic [7:0] AckByte  = 8'h02;
  localparam logic [7:0] NegDir   = 8'h01;

  // Query function codes.
  localparam logic [7:0] CodeSpeed  = 8'h35;
  localparam logic [7:0] CodePos    = 8'h36;
  localparam logic [7:0] CodePosErr = 8'h37;
  localparam logic [7:0] CodeStatus = 8'h3A;
  localparam logic [7:0] CodeHome   = 8'h3B;

  // Configuration register indexes.
  localparam logic CfgAddr    = 1'b0;
  localparam logic CfgTimeout = 1'b1;

  localparam logic [7:0] AddrReset    = 8'd1;
  localparam logic [7:0] TimeoutReset = 8'd50;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_SEND = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CODE = 2'd1,
    PH_DATA = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    TX_IDLE    = 3'd0,
    TX_PENDING = 3'd1,
    TX_ACK     = 3'd2,
    TX_NACK    = 3'd3,
    TX_TIMEOUT = 3'd4
  } tx_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic              frame_done;
    logic              send_accepted;
    logic [2:0]        tx_status;
    logic [7:0]        reply_ack;
    logic signed [27:0] position_pulses;
    logic signed [15:0] speed_rpm;
    logic signed [27:0] position_error_pulses;
    logic [7:0]        drive_flags;
    logic [7:0]        homing_state;
    logic [7:0]        sequence_res;
  } out_item_t;

  // Number of data bytes carried by a reply with the given function code.
  function automatic logic [2:0] needed_for(logic [7:0] code);
    logic [2:0] n;
    case (code)
      CodeSpeed:           n = 3'd3;
      CodePos, CodePosErr: n = 3'd5;
      default:             n = 3'd1;
    endcase
    return n;
  endfunction

  // True for the codes whose reply carries a reading.
  function automatic logic is_query(logic [7:0] code);
    return (code == CodeSpeed) || (code == CodePos) || (code == CodePosErr) ||
           (code == CodeStatus) || (code == CodeHome);
  endfunction

endpackage

// ===== rtl/stepper_link_response_tracker.sv =====
// Stepper link response tracker: reply frame parser and transaction tracker.
// A result appears in the output register in the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; the single output register sets the rate.
// The encoder magnitude is formed as data bytes arrive, so the tail byte only scales it.
// Reset (rst_ni low, asynchronous): parser idle, transaction idle, readings and
// counters zero, device address 1, timeout 50 ticks; the data byte store is not cleared.
`include "stepper_link_response_tracker_defines.svh"

module stepper_link_response_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slrt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slrt_pkg::out_item_t out_data_o
);

  // Configuration registers.
  logic [7:0] addr_q, timeout_q;

  // Parser state.
  slrt_pkg::phase_e phase_q, phase_d;
  logic [7:0] code_q, code_d;
  logic [7:0] data_q [slrt_pkg::DataBytes];
  logic [7:0] data_d [slrt_pkg::DataBytes];
  logic [slrt_pkg::CountW-1:0] count_q, count_d;
  logic [2:0] needed_q, needed_d;

  // Transaction state.
  slrt_pkg::tx_e tx_q, tx_d;
  logic [7:0] pend_code_q, pend_code_d;
  logic [7:0] ticks_q, ticks_d;
  logic [7:0] seq_q, seq_d;
  logic [7:0] ack_byte_q, ack_byte_d;

  // Readings.
  logic [27:0] pos_q, pos_d, pos_err_q, pos_err_d;
  logic [15:0] speed_q, speed_d;
  logic [7:0]  status_q, status_d, home_q, home_d;

  // Per-item flags and output handshake.
  logic done_q, done_d, sent_q, sent_d;
  logic out_valid_q;

  // Encoder magnitude prepared from the data bytes.
  logic [31:0] mag_q;
  logic        neg_q;

  logic       accept;
  logic       tail_ok;
  logic       match;
  logic       send_take;
  logic       dir_neg;
  logic [31:0] mag_raw, mag_abs;
  logic        enc_neg;
  logic [37:0] scaled;
  logic [27:0] pulses;
  logic [15:0] raw_speed;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= slrt_pkg::AddrReset;
      timeout_q <= slrt_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        slrt_pkg::CfgAddr:    addr_q    <= cfg_wdata_i;
        slrt_pkg::CfgTimeout: timeout_q <= cfg_wdata_i;
        default:              addr_q    <= addr_q;
      endcase
    end
  end

  // Parser next state.
  always_comb begin
    phase_d = phase_q;
    if (accept && (in_data_i.cmd == slrt_pkg::CMD_BYTE)) begin
      case (phase_q)
        slrt_pkg::PH_IDLE: begin
          if (in_data_i.value == addr_q) phase_d = slrt_pkg::PH_CODE;
        end
        slrt_pkg::PH_CODE: phase_d = slrt_pkg::PH_DATA;
        slrt_pkg::PH_DATA: begin
          if (count_d >= slrt_pkg::CountW'(needed_q)) phase_d = slrt_pkg::PH_TAIL;
        end
        default: phase_d = slrt_pkg::PH_IDLE;
      endcase
    end
  end

  // Frame fields collected by the parser.
  always_comb begin
    code_d   = code_q;
    count_d  = count_q;
    needed_d = needed_q;
    data_d   = data_q;
    if (accept && (in_data_i.cmd == slrt_pkg::CMD_BYTE)) begin
      case (phase_q)
        slrt_pkg::PH_CODE: begin
          code_d   = in_data_i.value;
          count_d  = '0;
          needed_d = slrt_pkg::needed_for(in_data_i.value);
        end
        slrt_pkg::PH_DATA: begin
          if (count_q < slrt_pkg::CountW'(slrt_pkg::DataBytes)) begin
            data_d[count_q[slrt_pkg::DataIdxW-1:0]] = in_data_i.value;
            count_d = count_q + 1'b1;
          end
        end
        default: count_d = count_q;
      endcase
    end
  end

  // Sign and magnitude of the encoder count, taken from the data bytes as they land.
  always_comb begin
    mag_raw = {data_d[1], data_d[2], data_d[3], data_d[4]};
    dir_neg = (data_d[0] == slrt_pkg::NegDir);
    if (dir_neg) begin
      enc_neg = (mag_raw != 32'd0) && (mag_raw <= 32'h8000_0000);
    end else begin
      enc_neg = mag_raw[31];
    end
    mag_abs = (dir_neg ^ enc_neg) ? (32'd0 - mag_raw) : mag_raw;
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_abs;
    neg_q <= enc_neg;
  end

  // Scale counts to pulses: (a * 3200 + 32768) / 65536 == (a * 25 + 256) >> 9.
  always_comb begin
    scaled = ({6'd0, mag_q} << 4) + ({6'd0, mag_q} << 3) + {6'd0, mag_q} + 38'd256;
    pulses = neg_q ? (28'd0 - scaled[36:9]) : scaled[36:9];
    raw_speed = {data_q[1], data_q[2]};
  end

  assign tail_ok = accept && (in_data_i.cmd == slrt_pkg::CMD_BYTE) &&
                   (phase_q == slrt_pkg::PH_TAIL) && (in_data_i.value == slrt_pkg::TailByte);
  assign match   = (tx_q == slrt_pkg::TX_PENDING) && (code_q == pend_code_q);
  assign send_take = accept && (in_data_i.cmd == slrt_pkg::CMD_SEND) &&
                     (tx_q != slrt_pkg::TX_PENDING);

  // Transaction tracking and reading updates.
  always_comb begin
    tx_d        = tx_q;
    pend_code_d = pend_code_q;
    ticks_d     = ticks_q;
    seq_d       = seq_q;
    ack_byte_d  = ack_byte_q;
    pos_d       = pos_q;
    pos_err_d   = pos_err_q;
    speed_d     = speed_q;
    status_d    = status_q;
    home_d      = home_q;
    done_d      = 1'b0;
    sent_d      = 1'b0;
    case (in_data_i.cmd)
      slrt_pkg::CMD_BYTE: begin
        if (tail_ok) begin
          done_d = 1'b1;
          case (code_q)
            slrt_pkg::CodeSpeed:
              speed_d = (data_q[0] == slrt_pkg::NegDir) ? (16'd0 - raw_speed) : raw_speed;
            slrt_pkg::CodePos:    pos_d     = pulses;
            slrt_pkg::CodePosErr: pos_err_d = pulses;
            slrt_pkg::CodeStatus: status_d  = data_q[0];
            slrt_pkg::CodeHome:   home_d    = data_q[0];
            default:              home_d    = home_q;
          endcase
          if (match) begin
            if (slrt_pkg::is_query(code_q)) begin
              tx_d = slrt_pkg::TX_ACK;
            end else begin
              ack_byte_d = data_q[0];
              tx_d = (data_q[0] == slrt_pkg::AckByte) ? slrt_pkg::TX_ACK : slrt_pkg::TX_NACK;
            end
          end
        end
      end
      slrt_pkg::CMD_SEND: begin
        if (tx_q != slrt_pkg::TX_PENDING) begin
          sent_d      = 1'b1;
          seq_d       = seq_q + 8'd1;
          tx_d        = slrt_pkg::TX_PENDING;
          pend_code_d = in_data_i.value;
          ack_byte_d  = 8'd0;
          ticks_d     = timeout_q;
        end
      end
      slrt_pkg::CMD_TICK: begin
        if (tx_q == slrt_pkg::TX_PENDING) begin
          if (ticks_q == 8'd0) tx_d = slrt_pkg::TX_TIMEOUT;
          else ticks_d = ticks_q - 8'd1;
        end
      end
      default: done_d = 1'b0;
    endcase
  end

  // Data byte store; its reset value is never relied on.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // State registers, loaded on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= slrt_pkg::PH_IDLE;
      code_q      <= '0;
      count_q     <= '0;
      needed_q    <= '0;
      tx_q        <= slrt_pkg::TX_IDLE;
      pend_code_q <= '0;
      ticks_q     <= '0;
      seq_q       <= '0;
      ack_byte_q  <= '0;
      pos_q       <= '0;
      pos_err_q   <= '0;
      speed_q     <= '0;
      status_q    <= '0;
      home_q      <= '0;
      done_q      <= 1'b0;
      sent_q      <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      code_q      <= code_d;
      count_q     <= count_d;
      needed_q    <= needed_d;
      tx_q        <= tx_d;
      pend_code_q <= pend_code_d;
      ticks_q     <= ticks_d;
      seq_q       <= seq_d;
      ack_byte_q  <= ack_byte_d;
      pos_q       <= pos_d;
      pos_err_q   <= pos_err_d;
      speed_q     <= speed_d;
      status_q    <= status_d;
      home_q      <= home_d;
      done_q      <= done_d;
      sent_q      <= sent_d;
    end
  end

  // Output valid: set by an input transfer, cleared when the result transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // The state registers double as the result register; they only move on a transfer.
  assign out_valid_o = out_valid_q;
  always_comb begin
    out_data_o.frame_done            = done_q;
    out_data_o.send_accepted         = sent_q;
    out_data_o.tx_status             = tx_q;
    out_data_o.reply_ack             = ack_byte_q;
    out_data_o.position_pulses       = pos_q;
    out_data_o.speed_rpm             = speed_q;
    out_data_o.position_error_pulses = pos_err_q;
    out_data_o.drive_flags           = status_q;
    out_data_o.homing_state          = home_q;
    out_data_o.sequence_res          = seq_q;
  end

  // A taken send always leaves the transaction pending.
  `SLRT_ASSERT_SAME(a_sent_pending, out_valid_o && sent_q, tx_q == slrt_pkg::TX_PENDING, "send not pending")
  // A taken send loads the timeout counter from the configuration.
  `SLRT_ASSERT_NEXT(a_send_loads_ticks, send_take, ticks_q == $past(timeout_q), "ticks not loaded")
  // A good tail byte in the tail phase completes a frame and returns the parser to idle.
  `SLRT_ASSERT_NEXT(a_tail_done, tail_ok, done_q && (phase_q == slrt_pkg::PH_IDLE), "tail not done")
  // The parser reaches the tail phase only with all data bytes collected.
  `SLRT_ASSERT_SAME(a_tail_count, phase_q == slrt_pkg::PH_TAIL, count_q >= slrt_pkg::CountW'(needed_q), "early tail")

endmodule

// ===== test/tb_stepper_link_response_tracker.sv =====
// Self-checking testbench for the stepper link response tracker.
// Depends on slrt_pkg and the stepper_link_response_tracker RTL only.
// A built-in predictor tracks the parser and transaction state to check every result.
module tb_stepper_link_response_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam logic [63:0] PulsesPerRev = 64'd3200;
  localparam logic [63:0] CountsPerRev = 64'd65536;
  // Two control function codes with plain acknowledge replies.
  localparam logic [7:0] CodeCtrlA = 8'hF3;
  localparam logic [7:0] CodeCtrlB = 8'h20;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  // Block ports.
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = 1'b0;
  logic [7:0]          cfg_wdata_i = 8'h00;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  slrt_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  slrt_pkg::out_item_t out_data_o;

  // Predicted link state and register copies.
  logic [7:0]       addr_cfg = slrt_pkg::AddrReset;
  logic [7:0]       timeout_cfg = slrt_pkg::TimeoutReset;
  slrt_pkg::phase_e parse_ph = slrt_pkg::PH_IDLE;
  logic [7:0]       frame_code_m = 8'h00;
  logic [7:0]       frame_bytes [slrt_pkg::DataBytes] = '{default: 8'h00};
  logic [3:0]       byte_count = 4'd0;
  logic [2:0]       bytes_needed = 3'd0;
  slrt_pkg::tx_e    txn_m = slrt_pkg::TX_IDLE;
  logic [7:0]       pend_code_m = 8'h00;
  logic [7:0]       ticks_m = 8'h00;
  logic [7:0]       sends_m = 8'h00;
  logic [7:0]       ack_byte_m = 8'h00;
  logic [27:0]      pos_m = '0;
  logic [15:0]      speed_m = '0;
  logic [27:0]      pos_err_m = '0;
  logic [7:0]       status_m = 8'h00;
  logic [7:0]       home_m = 8'h00;

  slrt_pkg::out_item_t link_reports_due [$];

  // Bookkeeping.
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          settings_used = 1;
  int unsigned cycles = 0;
  int          burst_left = 0;
  int          max_gap = 0;
  rx_mode_e    rx_mode = RX_FREE;
  int          hold_req = 0;
  int          hold_left = 0;
  int unsigned rx_beat = 0;

  stepper_link_response_tracker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Sign-magnitude encoder count scaled to command pulses, rounded half away from zero.
  function automatic logic [27:0] counts_to_pulses(logic [7:0] dir, logic [31:0] mag);
    logic [31:0] enc;
    logic [31:0] abs_cnt;
    logic [63:0] q;
    logic [31:0] r;
    enc = (dir == slrt_pkg::NegDir) ? -mag : mag;
    abs_cnt = enc[31] ? -enc : enc;
    q = ({32'd0, abs_cnt} * PulsesPerRev + CountsPerRev / 2) / CountsPerRev;
    r = enc[31] ? -q[31:0] : q[31:0];
    return r[27:0];
  endfunction

  // Advances the predicted state by one input transfer and returns the expected result.
  function automatic slrt_pkg::out_item_t next_link_report(slrt_pkg::in_item_t it);
    slrt_pkg::out_item_t r;
    logic        done;
    logic        took;
    logic        match;
    logic        query;
    logic [15:0] raw;
    logic [31:0] mag;
    done = 1'b0;
    took = 1'b0;
    case (slrt_pkg::cmd_e'(it.cmd))
      slrt_pkg::CMD_BYTE: begin
        case (parse_ph)
          slrt_pkg::PH_IDLE: begin
            if (it.value == addr_cfg) parse_ph = slrt_pkg::PH_CODE;
          end
          slrt_pkg::PH_CODE: begin
            frame_code_m = it.value;
            byte_count = 4'd0;
            if (it.value == slrt_pkg::CodeSpeed) bytes_needed = 3'd3;
            else if (it.value == slrt_pkg::CodePos || it.value == slrt_pkg::CodePosErr)
              bytes_needed = 3'd5;
            else bytes_needed = 3'd1;
            parse_ph = slrt_pkg::PH_DATA;
          end
          slrt_pkg::PH_DATA: begin
            if (byte_count < slrt_pkg::DataBytes) begin
              frame_bytes[byte_count] = it.value;
              byte_count++;
            end
            if (byte_count >= bytes_needed) parse_ph = slrt_pkg::PH_TAIL;
          end
          default: begin
            if (it.value == slrt_pkg::TailByte) begin
              done = 1'b1;
              match = (txn_m == slrt_pkg::TX_PENDING) && (frame_code_m == pend_code_m);
              query = 1'b1;
              mag = {frame_bytes[1], frame_bytes[2], frame_bytes[3], frame_bytes[4]};
              case (frame_code_m)
                slrt_pkg::CodeSpeed: begin
                  raw = {frame_bytes[1], frame_bytes[2]};
                  speed_m = (frame_bytes[0] == slrt_pkg::NegDir) ? -raw : raw;
                end
                slrt_pkg::CodePos:    pos_m = counts_to_pulses(frame_bytes[0], mag);
                slrt_pkg::CodePosErr: pos_err_m = counts_to_pulses(frame_bytes[0], mag);
                slrt_pkg::CodeStatus: status_m = frame_bytes[0];
                slrt_pkg::CodeHome:   home_m = frame_bytes[0];
                default: query = 1'b0;
              endcase
              if (match) begin
                if (query) begin
                  txn_m = slrt_pkg::TX_ACK;
                end else begin
                  ack_byte_m = frame_bytes[0];
                  txn_m = (frame_bytes[0] == slrt_pkg::AckByte) ? slrt_pkg::TX_ACK
                                                                : slrt_pkg::TX_NACK;
                end
              end
            end
            parse_ph = slrt_pkg::PH_IDLE;
          end
        endcase
      end
      slrt_pkg::CMD_SEND: begin
        if (txn_m != slrt_pkg::TX_PENDING) begin
          took = 1'b1;
          sends_m++;
          txn_m = slrt_pkg::TX_PENDING;
          pend_code_m = it.value;
          ack_byte_m = 8'h00;
          ticks_m = timeout_cfg;
        end
      end
      slrt_pkg::CMD_TICK: begin
        if (txn_m == slrt_pkg::TX_PENDING) begin
          if (ticks_m == 8'h00) txn_m = slrt_pkg::TX_TIMEOUT;
          else ticks_m--;
        end
      end
      default: ;
    endcase
    r.frame_done = done;
    r.send_accepted = took;
    r.tx_status = txn_m;
    r.reply_ack = ack_byte_m;
    r.position_pulses = pos_m;
    r.speed_rpm = speed_m;
    r.position_error_pulses = pos_err_m;
    r.drive_flags = status_m;
    r.homing_state = home_m;
    r.sequence_res = sends_m;
    return r;
  endfunction

  // Offers one item, waits for its transfer and then keeps or breaks the burst.
  task automatic send_item(slrt_pkg::cmd_e c, logic [7:0] v);
    slrt_pkg::in_item_t it;
    it.cmd = c;
    it.value = v;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    link_reports_due.push_back(next_link_report(it));
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      if (max_gap > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Sends a reply frame: address, code, lead byte, further data from mag, tail.
  task automatic send_reply(logic [7:0] code, logic [7:0] lead, logic [31:0] mag,
                            logic [7:0] tail);
    int n;
    if (code == slrt_pkg::CodeSpeed) n = 3;
    else if (code == slrt_pkg::CodePos || code == slrt_pkg::CodePosErr) n = 5;
    else n = 1;
    send_item(slrt_pkg::CMD_BYTE, addr_cfg);
    send_item(slrt_pkg::CMD_BYTE, code);
    send_item(slrt_pkg::CMD_BYTE, lead);
    for (int i = 1; i < n; i++) send_item(slrt_pkg::CMD_BYTE, mag[31 - 8 * (i - 1) -: 8]);
    send_item(slrt_pkg::CMD_BYTE, tail);
  endtask

  // Lowers valid and waits until every predicted result has been checked.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (link_reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive cycles; the block must be idle.
  task automatic apply_settings(logic [7:0] addr, logic [7:0] tmo);
    cfg_we_i <= 1'b1;
    cfg_index_i <= slrt_pkg::CfgAddr;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    addr_cfg = addr;
    cfg_index_i <= slrt_pkg::CfgTimeout;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    timeout_cfg = tmo;
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0: return slrt_pkg::CodeSpeed;
      1: return slrt_pkg::CodePos;
      2: return slrt_pkg::CodePosErr;
      3: return slrt_pkg::CodeStatus;
      4: return slrt_pkg::CodeHome;
      5: return CodeCtrlA;
      6: return CodeCtrlB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed frames, often answering the pending send, mixed with sends,
  // tick runs, stray bytes, idle commands and frames with a broken tail.
  task automatic run_random(int n_items);
    int          stop_at;
    int unsigned roll;
    logic [7:0]  code;
    logic [7:0]  lead;
    logic [31:0] mag;
    logic [7:0]  tail;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        code = (txn_m == slrt_pkg::TX_PENDING && $urandom_range(0, 2) != 0) ? pend_code_m
                                                                           : pick_code();
        case ($urandom_range(0, 3))
          0: lead = 8'h00;
          1: lead = slrt_pkg::NegDir;
          2: lead = slrt_pkg::AckByte;
          default: lead = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 6))
          0: mag = 32'h0000_0000;
          1: mag = 32'h0000_0100;
          2: mag = 32'h8000_0000;
          3: mag = 32'hFFFF_FFFF;
          4: mag = 32'h7FFF_FFFF;
          default: mag = $urandom;
        endcase
        tail = slrt_pkg::TailByte;
        if ($urandom_range(0, 9) == 0) begin
          tail = 8'($urandom_range(0, 255));
          if (tail == slrt_pkg::TailByte) tail = tail ^ 8'h01;
        end
        send_reply(code, lead, mag, tail);
      end else if (roll < 60) begin
        send_item(slrt_pkg::CMD_SEND, pick_code());
      end else if (roll < 78) begin
        repeat ($urandom_range(1, 8)) send_item(slrt_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
      end else if (roll < 94) begin
        send_item(slrt_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_item(slrt_pkg::CMD_NONE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Stray inputs, a refused send, a query reply, an unrelated reply and a nack.
  task automatic test_directed_basics();
    rx_mode = RX_FREE;
    max_gap = 0;
    send_item(slrt_pkg::CMD_TICK, 8'h00);
    send_item(slrt_pkg::CMD_NONE, 8'hFF);
    send_item(slrt_pkg::CMD_BYTE, 8'h55);
    send_item(slrt_pkg::CMD_SEND, slrt_pkg::CodePos);
    send_item(slrt_pkg::CMD_SEND, slrt_pkg::CodePosErr);
    send_reply(slrt_pkg::CodePos, 8'h00, 32'h8000_0000, slrt_pkg::TailByte);
    send_item(slrt_pkg::CMD_SEND, CodeCtrlA);
    send_reply(CodeCtrlB, slrt_pkg::AckByte, 32'h0, slrt_pkg::TailByte);
    send_reply(CodeCtrlA, 8'h07, 32'h0, slrt_pkg::TailByte);
    wait_quiet();
  endtask

  // Timeout on the first tick with a zero limit and on the 256th with the largest.
  task automatic test_timeout_limits();
    rx_mode = RX_RANDOM;
    max_gap = 3;
    apply_settings(8'h00, 8'h00);
    send_item(slrt_pkg::CMD_SEND, slrt_pkg::CodeStatus);
    send_item(slrt_pkg::CMD_TICK, 8'hAA);
    send_item(slrt_pkg::CMD_TICK, 8'h55);
    wait_quiet();
    apply_settings(8'hFF, 8'hFF);
    send_item(slrt_pkg::CMD_SEND, slrt_pkg::CodeHome);
    repeat (257) send_item(slrt_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    wait_quiet();
  endtask

  // Random traffic under several register settings and idling styles.
  task automatic test_register_sweep();
    rx_mode = RX_RANDOM;
    max_gap = 4;
    apply_settings(slrt_pkg::AddrReset, slrt_pkg::TimeoutReset);
    run_random(20);
    wait_quiet();
    rx_mode = RX_PATTERN;
    max_gap = 0;
    apply_settings(8'h00, 8'h00);
    run_random(20);
    wait_quiet();
    rx_mode = RX_FREE;
    max_gap = 6;
    apply_settings(8'hFF, 8'hFF);
    run_random(20);
    wait_quiet();
    rx_mode = RX_RANDOM;
    max_gap = 2;
    apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(1, 6)));
    run_random(20);
    wait_quiet();
  endtask

  // The receiver holds off for a long stretch while items keep coming back to back.
  task automatic test_backpressure();
    rx_mode = RX_FREE;
    max_gap = 0;
    apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 3)));
    hold_req = 120;
    run_random(40);
    wait_quiet();
  endtask

  // Receiver stalls: a requested long hold first, otherwise the current pattern.
  always @(posedge clk_i) begin
    rx_beat++;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_ready_i <= ($urandom_range(0, 99) < 70);
        RX_PATTERN: out_ready_i <= ((rx_beat % 7) < 5);
        default:    out_ready_i <= 1'b1;
      endcase
    end
  end

  // Compares a result field against its prediction.
  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Checks each result transfer against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    slrt_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (link_reports_due.size() == 0) begin
        $error("result transfer with no prediction waiting");
        mismatches++;
      end else begin
        want = link_reports_due.pop_front();
        results_checked++;
        check_field("frame_done", want.frame_done, out_data_o.frame_done);
        check_field("send_accepted", want.send_accepted, out_data_o.send_accepted);
        check_field("tx_status", want.tx_status, out_data_o.tx_status);
        check_field("reply_ack", want.reply_ack, out_data_o.reply_ack);
        check_field("position_pulses", want.position_pulses, out_data_o.position_pulses);
        check_field("speed_rpm", want.speed_rpm, out_data_o.speed_rpm);
        check_field("position_error_pulses", want.position_error_pulses,
                    out_data_o.position_error_pulses);
        check_field("drive_flags", want.drive_flags, out_data_o.drive_flags);
        check_field("homing_state", want.homing_state, out_data_o.homing_state);
        check_field("sequence_res", want.sequence_res, out_data_o.sequence_res);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    test_timeout_limits();
    test_register_sweep();
    test_backpressure();
    $display("Covered %0d input transfers and %0d checked results over %0d register settings,",
             items_sent, results_checked, settings_used);
    $display("including timeouts at both limits and a long output stall.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/slrt_pkg.sv
rtl/stepper_link_response_tracker.sv
test/tb_stepper_link_response_tracker.sv
